/* design/erm_pkg.sv */
// Shared types, constants and helper functions for the Euler angle to rotation matrix block.
// Used by every module of the block but erm_flow; depends on nothing.
`default_nettype none

package erm_pkg;

    localparam int IN_W    = 18;
    localparam int OUT_W   = 16;
    localparam int NUM_OUT = 9;
    localparam int CW      = 34;
    localparam int MW      = CW + 1;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = NUM_OUT * OUT_W;

    localparam int ANGLE_RANGE = 131072;

    localparam longint unsigned DEG2RAD_Q40 = 64'd19190098069;
    localparam int D_LO_W = 18;
    localparam int D_HI_W = 17;
    localparam logic [D_HI_W-1:0] D_HI = D_HI_W'(DEG2RAD_Q40 >> D_LO_W);
    localparam logic [D_LO_W-1:0] D_LO = D_LO_W'(DEG2RAD_Q40);

    typedef logic signed [IN_W-1:0]  angle_t;
    typedef logic signed [CW-1:0]    fx_t;
    typedef logic signed [MW-1:0]    sum_t;
    typedef logic [OUT_W-1:0]        coef_t;

    localparam fx_t CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic neg;
        logic flip;
    } quad_t;

    function automatic fx_t atan_q30(input logic [4:0] idx);
        fx_t v;
        case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            5'd24:   v = 34'sh00000003F;
            5'd25:   v = 34'sh00000001F;
            5'd26:   v = 34'sh00000000F;
            5'd27:   v = 34'sh000000007;
            5'd28:   v = 34'sh000000003;
            5'd29:   v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic fx_t mul30(input fx_t a, input fx_t b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + ((2*CW)'(1) << 29);
        return p[CW+29:30];
    endfunction

endpackage

`default_nettype wire

/* design/erm_flow.sv */
// Flow control: valid bits of the pipeline stages, global advance enable and
// the two-entry output skid buffer. Depends on nothing outside this file.
`default_nettype none

module erm_flow #(
    parameter int N  = 28,
    parameter int DW = 144
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               en,
    input  wire logic [DW-1:0] last_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [DW-1:0]      out_data
);

    logic [N-1:0]  v_reg, v_next;
    logic          out_valid_reg, out_valid_next;
    logic          spare_valid_reg, spare_valid_next;
    logic [DW-1:0] out_data_reg, spare_data_reg;
    logic          push, load_out;

    assign en       = !v_reg[N-1] || !spare_valid_reg;
    assign in_ready = en;
    assign push     = v_reg[N-1] && !spare_valid_reg;
    assign load_out = out_ready || !out_valid_reg;

    always_comb
    begin
        v_next           = v_reg;
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (en)
        begin
            v_next = {v_reg[N-2:0], in_valid};
        end
        if (load_out)
        begin
            if (spare_valid_reg)
            begin
                out_valid_next   = 1'b1;
                spare_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg           <= v_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= spare_valid_reg ? spare_data_reg : last_data;
        end
        else if (push)
        begin
            spare_data_reg <= last_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* design/erm_prep.sv */
// Angle preparation: reduction modulo 360 degrees, fold to the right half plane
// and conversion to radians in Q3.30. Seven stages. Depends on erm_pkg.
`default_nettype none

module erm_prep #(
    parameter int AF = 7
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire erm_pkg::angle_t a,
    output erm_pkg::fx_t        z,
    output erm_pkg::quad_t      quad
);

    localparam int FULL    = 360 << AF;
    localparam int HALF    = 180 << AF;
    localparam int QTR     = 90 << AF;
    localparam int OFF     = FULL * ((erm_pkg::ANGLE_RANGE + FULL - 1) / FULL);
    localparam int U_W     = $clog2(erm_pkg::ANGLE_RANGE + OFF);
    localparam int SH      = U_W;
    localparam longint RECIP = (longint'(1) << SH) / FULL;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int P_W     = U_W + RECIP_W;
    localparam int R_W     = $clog2(2 * FULL);
    localparam int RN_W    = R_W - 1;
    localparam int M_W     = $clog2(QTR + 1);
    localparam int PH_W    = M_W + erm_pkg::D_HI_W;
    localparam int PL_W    = M_W + erm_pkg::D_LO_W;
    localparam int SUM_W   = M_W + erm_pkg::D_HI_W + erm_pkg::D_LO_W + 1;
    localparam int SHR     = 10 + AF;

    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [U_W-1:0]     FULL_U  = U_W'(FULL);

    logic [U_W-1:0]   u_reg, u2_reg;
    logic [P_W-1:0]   prod_reg;
    logic [R_W-1:0]   r0_reg;
    logic [RN_W-1:0]  r_reg;
    logic [M_W-1:0]   mag_reg;
    erm_pkg::quad_t   q5_reg, q6_reg, q7_reg;
    logic [PH_W-1:0]  phi_reg;
    logic [PL_W-1:0]  plo_reg;
    erm_pkg::fx_t     z_reg;

    logic [U_W-1:0]   u_next, qf;
    logic [P_W-1:0]   prod_next;
    logic [R_W-1:0]   r0_next;
    logic [RN_W-1:0]  r_next;
    logic [M_W-1:0]   mag_next;
    erm_pkg::quad_t   q5_next;
    logic [SUM_W-1:0] sum;
    erm_pkg::fx_t     z_next;

    always_comb
    begin
        u_next    = U_W'(int'(a) + OFF);
        prod_next = u_reg * RECIP_V;
        qf        = U_W'(prod_reg[P_W-1:SH]) * FULL_U;
        r0_next   = R_W'(u2_reg - qf);
        r_next    = (r0_reg >= R_W'(FULL)) ? RN_W'(r0_reg - R_W'(FULL)) : RN_W'(r0_reg);

        if (r_reg <= RN_W'(QTR))
        begin
            mag_next = M_W'(r_reg);
            q5_next  = '{neg: 1'b0, flip: 1'b0};
        end
        else if (r_reg < RN_W'(HALF))
        begin
            mag_next = M_W'(RN_W'(HALF) - r_reg);
            q5_next  = '{neg: 1'b1, flip: 1'b1};
        end
        else if (r_reg < RN_W'(FULL - QTR))
        begin
            mag_next = M_W'(r_reg - RN_W'(HALF));
            q5_next  = '{neg: 1'b0, flip: 1'b1};
        end
        else
        begin
            mag_next = M_W'(RN_W'(FULL) - r_reg);
            q5_next  = '{neg: 1'b1, flip: 1'b0};
        end

        sum = (SUM_W'(phi_reg) << erm_pkg::D_LO_W) + SUM_W'(plo_reg)
            + (SUM_W'(1) << (SHR - 1));
        z_next = erm_pkg::CW'(sum >> SHR);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            u2_reg   <= u_reg;
            prod_reg <= prod_next;
            r0_reg   <= r0_next;
            r_reg    <= r_next;
            mag_reg  <= mag_next;
            q5_reg   <= q5_next;
            phi_reg  <= mag_reg * erm_pkg::D_HI;
            plo_reg  <= mag_reg * erm_pkg::D_LO;
            q6_reg   <= q5_reg;
            z_reg    <= z_next;
            q7_reg   <= q6_reg;
        end
    end

    assign z    = z_reg;
    assign quad = q7_reg;

endmodule

`default_nettype wire

/* design/erm_cordic.sv */
// Rotation-mode CORDIC, one iteration per stage, then a stage that restores
// the quadrant signs. Depends on erm_pkg.
`default_nettype none

module erm_cordic #(
    parameter int T = 16
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire erm_pkg::fx_t   z,
    input  wire erm_pkg::quad_t quad,
    output erm_pkg::fx_t        sin_o,
    output erm_pkg::fx_t        cos_o
);

    erm_pkg::fx_t   x_reg [T];
    erm_pkg::fx_t   y_reg [T];
    erm_pkg::fx_t   z_reg [T];
    erm_pkg::quad_t q_reg [T];
    erm_pkg::fx_t   sin_reg, cos_reg;

    for (genvar i = 0; i < T; i++)
    begin : g_iter
        erm_pkg::fx_t   xi, yi, zi;
        erm_pkg::quad_t qi;
        erm_pkg::fx_t   x_next, y_next, z_next;

        if (i == 0)
        begin : g_first
            assign xi = erm_pkg::CORDIC_GAIN;
            assign yi = '0;
            assign zi = z;
            assign qi = quad;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign qi = q_reg[i-1];
        end

        always_comb
        begin
            if (!zi[erm_pkg::CW-1])
            begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - erm_pkg::atan_q30(5'(i));
            end
            else
            begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + erm_pkg::atan_q30(5'(i));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                q_reg[i] <= qi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= (q_reg[T-1].neg ^ q_reg[T-1].flip) ? -y_reg[T-1] : y_reg[T-1];
            cos_reg <= q_reg[T-1].flip ? -x_reg[T-1] : x_reg[T-1];
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

`default_nettype wire

/* design/erm_matrix.sv */
// Matrix entries from the sines and cosines: two product stages, a sum stage
// and a rounding and saturation stage. Depends on erm_pkg.
`default_nettype none

module erm_matrix #(
    parameter int CF = 14
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire erm_pkg::fx_t sp,
    input  wire erm_pkg::fx_t cp,
    input  wire erm_pkg::fx_t sy,
    input  wire erm_pkg::fx_t cy,
    input  wire erm_pkg::fx_t sr,
    input  wire erm_pkg::fx_t cr,
    output logic [erm_pkg::OUT_DATA_W-1:0] coef
);

    localparam int S      = 30 - CF;
    localparam int QW     = erm_pkg::MW + 1;
    localparam logic signed [QW-1:0] RND = (S > 0) ? QW'(longint'(1) << (S - 1)) : '0;
    localparam logic signed [QW-1:0] LIM = QW'(longint'(1) << CF);

    erm_pkg::fx_t spsr_reg, spcr_reg, cycr_reg, cpsr_reg, sycr_reg, cysr_reg;
    erm_pkg::fx_t cpcr_reg, sysr_reg, sycp_reg, cycp_reg, sy1_reg, cy1_reg, nsp1_reg;

    erm_pkg::fx_t t0_reg, t2_reg, t3_reg, t5_reg;
    erm_pkg::fx_t cycr2_reg, cpsr2_reg, sycr2_reg, cysr2_reg;
    erm_pkg::fx_t cpcr2_reg, sysr2_reg, sycp2_reg, cycp2_reg, nsp2_reg;

    erm_pkg::sum_t m_reg [erm_pkg::NUM_OUT];
    erm_pkg::sum_t m_next [erm_pkg::NUM_OUT];
    logic [erm_pkg::OUT_DATA_W-1:0] coef_reg, coef_next;

    always_comb
    begin
        m_next[0] = erm_pkg::MW'(cycr2_reg) + erm_pkg::MW'(t0_reg);
        m_next[1] = erm_pkg::MW'(cpsr2_reg);
        m_next[2] = erm_pkg::MW'(t2_reg) - erm_pkg::MW'(sycr2_reg);
        m_next[3] = erm_pkg::MW'(t3_reg) - erm_pkg::MW'(cysr2_reg);
        m_next[4] = erm_pkg::MW'(cpcr2_reg);
        m_next[5] = erm_pkg::MW'(sysr2_reg) + erm_pkg::MW'(t5_reg);
        m_next[6] = erm_pkg::MW'(sycp2_reg);
        m_next[7] = erm_pkg::MW'(nsp2_reg);
        m_next[8] = erm_pkg::MW'(cycp2_reg);
    end

    always_comb
    begin
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] q;
        coef_next = '0;
        for (int k = 0; k < erm_pkg::NUM_OUT; k++)
        begin
            v = QW'(m_reg[k]) + RND;
            q = v >>> S;
            if (q > LIM)
            begin
                q = LIM;
            end
            else if (q < -LIM)
            begin
                q = -LIM;
            end
            coef_next[k*erm_pkg::OUT_W +: erm_pkg::OUT_W] = q[erm_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spsr_reg <= erm_pkg::mul30(sp, sr);
            spcr_reg <= erm_pkg::mul30(sp, cr);
            cycr_reg <= erm_pkg::mul30(cy, cr);
            cpsr_reg <= erm_pkg::mul30(cp, sr);
            sycr_reg <= erm_pkg::mul30(sy, cr);
            cysr_reg <= erm_pkg::mul30(cy, sr);
            cpcr_reg <= erm_pkg::mul30(cp, cr);
            sysr_reg <= erm_pkg::mul30(sy, sr);
            sycp_reg <= erm_pkg::mul30(sy, cp);
            cycp_reg <= erm_pkg::mul30(cy, cp);
            sy1_reg  <= sy;
            cy1_reg  <= cy;
            nsp1_reg <= -sp;

            t0_reg    <= erm_pkg::mul30(sy1_reg, spsr_reg);
            t2_reg    <= erm_pkg::mul30(cy1_reg, spsr_reg);
            t3_reg    <= erm_pkg::mul30(sy1_reg, spcr_reg);
            t5_reg    <= erm_pkg::mul30(cy1_reg, spcr_reg);
            cycr2_reg <= cycr_reg;
            cpsr2_reg <= cpsr_reg;
            sycr2_reg <= sycr_reg;
            cysr2_reg <= cysr_reg;
            cpcr2_reg <= cpcr_reg;
            sysr2_reg <= sysr_reg;
            sycp2_reg <= sycp_reg;
            cycp2_reg <= cycp_reg;
            nsp2_reg  <= nsp1_reg;

            m_reg    <= m_next;
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

/* design/euler_to_rotation_matrix.sv */
// Top level of the Euler angle to rotation matrix block.
// Depends on erm_pkg, erm_flow, erm_prep, erm_cordic and erm_matrix.
//
// Usage:
// The slave channel takes one word per accepted handshake holding pitch, yaw
// and roll in degrees. The master channel returns one word per input word with
// the nine entries of the Y*X*Z rotation matrix in Q1.14, column by column.
// The datapath is a pipeline of TRIG_ITERATIONS + 12 register stages: seven for
// angle reduction and conversion to radians, one per CORDIC iteration plus a
// sign stage, and four for the matrix products, sums and rounding. The output
// register adds one more. While s_tready is high a new word can be accepted
// every cycle; the rate is one word per cycle. When the receiver stalls, a
// two-entry output skid buffer takes the word in flight and the whole pipeline
// then holds; s_tready depends only on registers.
// Reset clears all valid bits and the skid buffer; no word is in flight after it.
`default_nettype none

module euler_to_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int COEF_FRAC_BITS  = 14,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pitch_deg [17:0], yaw_deg [35:18], roll_deg [53:36], zero [55:54]
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row0_col0 .. row2_col0, row0_col1 .. row2_col1, row0_col2 .. row2_col2,
    // 16 bits each from bit 0 upward
    output logic [143:0]      m_tdata
);

    localparam int N = TRIG_ITERATIONS + 12;

    logic         en;
    erm_pkg::fx_t z [3];
    erm_pkg::quad_t quad [3];
    erm_pkg::fx_t s [3];
    erm_pkg::fx_t c [3];
    erm_pkg::angle_t ang [3];
    logic [erm_pkg::OUT_DATA_W-1:0] coef;

    assign ang[0] = s_tdata[17:0];
    assign ang[1] = s_tdata[35:18];
    assign ang[2] = s_tdata[53:36];

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        erm_prep #(
            .AF (ANGLE_FRAC_BITS)
        ) u_prep (
            .clk  (clk),
            .en   (en),
            .a    (ang[k]),
            .z    (z[k]),
            .quad (quad[k])
        );

        erm_cordic #(
            .T (TRIG_ITERATIONS)
        ) u_cordic (
            .clk   (clk),
            .en    (en),
            .z     (z[k]),
            .quad  (quad[k]),
            .sin_o (s[k]),
            .cos_o (c[k])
        );
    end

    erm_matrix #(
        .CF (COEF_FRAC_BITS)
    ) u_matrix (
        .clk  (clk),
        .en   (en),
        .sp   (s[0]),
        .cp   (c[0]),
        .sy   (s[1]),
        .cy   (c[1]),
        .sr   (s[2]),
        .cr   (c[2]),
        .coef (coef)
    );

    erm_flow #(
        .N  (N),
        .DW (erm_pkg::OUT_DATA_W)
    ) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .en        (en),
        .last_data (coef),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input held off while no output word is pending.");

    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |=> s_tready)
        else $error("Input not ready one cycle after the receiver was ready.");

endmodule

`default_nettype wire
